@@ rtl/pm_pkg.sv @@
// Shared codes and controller/datapath interface types for the polynomial multiplier.
package pm_pkg;

	localparam logic [1:0] KIND_LOAD_A   = 2'd0;
	localparam logic [1:0] KIND_LOAD_B   = 2'd1;
	localparam logic [1:0] KIND_MULTIPLY = 2'd2;

	typedef struct packed {
		logic load_a;     // append coefficient to A
		logic load_b;     // append coefficient to B
		logic start;      // new product: clear nonzero tracking
		logic clear;      // drop both operands and the overflow flag
		logic rd;         // read A[idx_i] and B[idx_j]
		logic mul;        // register the partial product
		logic acc;        // accumulate the partial product
		logic acc_first;  // first term of this coefficient
		logic acc_end;    // last term: write the coefficient to the product store
		logic emit_rd;    // read product store at idx_k
		logic out_load;   // load the output register
		logic out_zero;   // output is the zero polynomial
		logic out_last;   // output is the final coefficient
	} cmd_t;

	typedef struct packed {
		logic out_free;   // output register can take a beat this cycle
		logic nz_seen;    // product has at least one nonzero coefficient
	} sts_t;

endpackage

@@ rtl/pm_datapath.sv @@
// Operand stores, shared multiplier, accumulator, product store and output register.
module pm_datapath import pm_pkg::*; #(
	parameter int MaxTerms = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [$clog2(MaxTerms)-1:0]     idx_i,
	input  logic [$clog2(MaxTerms)-1:0]     idx_j,
	input  logic [$clog2(2*MaxTerms-1)-1:0] idx_k,
	input  logic signed [31:0]  coefficient,
	input  logic                out_ready,
	output sts_t                sts,
	output logic [$clog2(MaxTerms+1)-1:0]   count_a,
	output logic [$clog2(MaxTerms+1)-1:0]   count_b,
	output logic [$clog2(2*MaxTerms-1)-1:0] last_nz,
	output logic                out_valid,
	output logic signed [31:0]  product_coefficient,
	output logic [4:0]          power,
	output logic                last,
	output logic                is_zero,
	output logic                load_overflow
);

	localparam int ProdLen = 2 * MaxTerms - 1;
	localparam int IW      = $clog2(MaxTerms);
	localparam int CW      = $clog2(MaxTerms + 1);
	localparam int KW      = $clog2(ProdLen);

	logic [31:0]   a_mem [MaxTerms];
	logic [31:0]   b_mem [MaxTerms];
	logic [31:0]   p_mem [ProdLen];

	logic [CW-1:0] ca_q, cb_q;
	logic          ovf_q;
	logic          nz_q;
	logic [KW-1:0] last_nz_q;
	logic [31:0]   a_rd_q, b_rd_q, prod_q, acc_q, p_rd_q;
	logic [31:0]   acc_sum;
	logic          a_room, b_room;
	logic          out_valid_q;

	assign a_room  = ca_q < CW'(MaxTerms);
	assign b_room  = cb_q < CW'(MaxTerms);
	assign acc_sum = (cmd.acc_first ? 32'd0 : acc_q) + prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q        <= '0;
			cb_q        <= '0;
			ovf_q       <= 1'b0;
			nz_q        <= 1'b0;
			last_nz_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_a) begin
				if (a_room) ca_q <= ca_q + CW'(1);
				else        ovf_q <= 1'b1;
			end
			if (cmd.load_b) begin
				if (b_room) cb_q <= cb_q + CW'(1);
				else        ovf_q <= 1'b1;
			end
			if (cmd.clear) begin
				ca_q  <= '0;
				cb_q  <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.start) nz_q <= 1'b0;
			else if (cmd.acc && cmd.acc_end && acc_sum != 32'd0) begin
				nz_q      <= 1'b1;
				last_nz_q <= idx_k;
			end
			if (cmd.out_load)  out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// stores and payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_a && a_room) a_mem[ca_q[IW-1:0]] <= coefficient;
		if (cmd.load_b && b_room) b_mem[cb_q[IW-1:0]] <= coefficient;
		if (cmd.rd) begin
			a_rd_q <= a_mem[idx_i];
			b_rd_q <= b_mem[idx_j];
		end
		if (cmd.mul) prod_q <= a_rd_q * b_rd_q;   // low word only, sign does not matter
		if (cmd.acc) begin
			acc_q <= acc_sum;
			if (cmd.acc_end) p_mem[idx_k] <= acc_sum;
		end
		if (cmd.emit_rd) p_rd_q <= p_mem[idx_k];
		if (cmd.out_load) begin
			product_coefficient <= cmd.out_zero ? 32'sd0 : $signed(p_rd_q);
			power               <= cmd.out_zero ? 5'd0 : 5'(idx_k);
			last                <= cmd.out_zero | cmd.out_last;
			is_zero             <= cmd.out_zero;
			load_overflow       <= ovf_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.nz_seen  = nz_q;
	assign count_a      = ca_q;
	assign count_b      = cb_q;
	assign last_nz      = last_nz_q;
	assign out_valid    = out_valid_q;

endmodule

@@ rtl/pm_ctrl.sv @@
// Sequencer: walks the convolution one partial product at a time, then emits the product.
module pm_ctrl import pm_pkg::*; #(
	parameter int MaxTerms = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  sts_t                sts,
	input  logic [$clog2(MaxTerms+1)-1:0]   count_a,
	input  logic [$clog2(MaxTerms+1)-1:0]   count_b,
	input  logic [$clog2(2*MaxTerms-1)-1:0] last_nz,
	output cmd_t                cmd,
	output logic [$clog2(MaxTerms)-1:0]     idx_i,
	output logic [$clog2(MaxTerms)-1:0]     idx_j,
	output logic [$clog2(2*MaxTerms-1)-1:0] idx_k
);

	localparam int IW = $clog2(MaxTerms);
	localparam int KW = $clog2(2 * MaxTerms - 1);
	localparam int WW = KW + 1;

	typedef enum logic [2:0] {
		IDLE, C_RD, C_MUL, C_ACC, C_CHK, E_RD, E_LD, Z_LD
	} state_t;

	state_t        state_q;
	logic [KW-1:0] k_q;
	logic [IW-1:0] i_q;
	logic          first_q;

	logic [WW-1:0] kw, iw, na, nb, i_hi, k_nx, i_lo_nx, k_max;
	logic          acc_end, k_end, operands_ok, mul_beat;

	assign kw    = WW'(k_q);
	assign iw    = WW'(i_q);
	assign na    = WW'(count_a);
	assign nb    = WW'(count_b);
	assign i_hi  = (kw < na) ? kw : na - WW'(1);
	assign k_nx  = kw + WW'(1);
	// first A index that pairs with a valid B index for the next coefficient
	assign i_lo_nx = (k_nx >= nb) ? k_nx - nb + WW'(1) : '0;
	assign k_max   = na + nb - WW'(2);
	assign acc_end = iw == i_hi;
	assign k_end   = kw == k_max;

	assign operands_ok = count_a != '0 && count_b != '0;
	assign in_ready    = state_q == IDLE;
	assign mul_beat    = in_valid && in_ready && kind == KIND_MULTIPLY;

	assign idx_i = i_q;
	assign idx_j = IW'(kw - iw);
	assign idx_k = k_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load_a = kind == KIND_LOAD_A;
					cmd.load_b = kind == KIND_LOAD_B;
					cmd.start  = kind == KIND_MULTIPLY;
				end
			end
			C_RD:  cmd.rd  = 1'b1;
			C_MUL: cmd.mul = 1'b1;
			C_ACC: begin
				cmd.acc       = 1'b1;
				cmd.acc_first = first_q;
				cmd.acc_end   = acc_end;
			end
			C_CHK: ;
			E_RD:  cmd.emit_rd = 1'b1;
			E_LD: begin
				cmd.out_load = sts.out_free;
				cmd.out_last = k_q == last_nz;
				cmd.clear    = sts.out_free && k_q == last_nz;
			end
			Z_LD: begin
				cmd.out_load = sts.out_free;
				cmd.out_zero = 1'b1;
				cmd.clear    = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			k_q     <= '0;
			i_q     <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (mul_beat) begin
						k_q     <= '0;
						i_q     <= '0;
						first_q <= 1'b1;
						state_q <= operands_ok ? C_RD : Z_LD;
					end
				end
				C_RD:  state_q <= C_MUL;
				C_MUL: state_q <= C_ACC;
				C_ACC: begin
					if (acc_end) begin
						if (k_end) begin
							first_q <= 1'b0;
							state_q <= C_CHK;
						end else begin
							k_q     <= k_q + KW'(1);
							i_q     <= IW'(i_lo_nx);
							first_q <= 1'b1;
							state_q <= C_RD;
						end
					end else begin
						first_q <= 1'b0;
						i_q     <= IW'(iw + WW'(1));
						state_q <= C_RD;
					end
				end
				C_CHK: begin
					k_q     <= '0;
					state_q <= sts.nz_seen ? E_RD : Z_LD;
				end
				E_RD: state_q <= E_LD;
				E_LD: begin
					if (sts.out_free) begin
						if (k_q == last_nz) begin
							state_q <= IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= E_RD;
						end
					end
				end
				Z_LD: begin
					if (sts.out_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

@@ rtl/polynomial_multiply.sv @@
// Schoolbook polynomial multiplier: load beats are accepted whenever the block is idle; a
// multiply beat stalls the input while one shared 32x32 multiplier walks the convolution one
// partial product at a time (registered operand read, registered multiply, accumulate),
// na*nb partial products for operands of na and nb terms, then each product coefficient
// takes a registered product-store read and an output load, plus any output stall.
// An empty operand skips the walk and gives the single zero beat; a product whose
// coefficients are all zero gives it after the walk. Operand stores
// need no clearing pass, and loads are taken again once the last result sits in the
// output register.
module polynomial_multiply import pm_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [31:0] coefficient,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] product_coefficient,
	output logic [4:0]         power,
	output logic               last,
	output logic               is_zero,
	output logic               load_overflow
);

	localparam int IW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int KW = $clog2(2 * MAX_TERMS - 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] idx_i, idx_j;
	logic [KW-1:0] idx_k, last_nz;
	logic [CW-1:0] count_a, count_b;

	pm_ctrl #(.MaxTerms(MAX_TERMS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.count_a  (count_a),
		.count_b  (count_b),
		.last_nz  (last_nz),
		.cmd      (cmd),
		.idx_i    (idx_i),
		.idx_j    (idx_j),
		.idx_k    (idx_k)
	);

	pm_datapath #(.MaxTerms(MAX_TERMS)) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.idx_i               (idx_i),
		.idx_j               (idx_j),
		.idx_k               (idx_k),
		.coefficient         (coefficient),
		.out_ready           (out_ready),
		.sts                 (sts),
		.count_a             (count_a),
		.count_b             (count_b),
		.last_nz             (last_nz),
		.out_valid           (out_valid),
		.product_coefficient (product_coefficient),
		.power               (power),
		.last                (last),
		.is_zero             (is_zero),
		.load_overflow       (load_overflow)
	);

`ifndef SYNTH
	// a multiply beat always holds off the next input in the cycle after it
	a_mul_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_MULTIPLY) |=> !in_ready)
		else $error("input taken right after a multiply beat");

	// the zero polynomial is a single beat with power and coefficient zero
	a_zero_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_zero) |-> (last && power == 5'd0 && product_coefficient == 32'sd0))
		else $error("malformed zero-product beat");

	// operands are only loaded while no product is being formed
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_a || cmd.load_b) |-> in_ready)
		else $error("operand load outside idle");
`endif

endmodule
